### hw/rtl/jdc_pkg.sv
// Shared constants, stage control type and month table of the Julian date converter.
package jdc_pkg;

    localparam int JDC_FRAC_BITS    = 32;
    localparam int JDC_DAY_INT_BITS = 23;
    localparam int JDC_IN_W         = 55;

    localparam int JDC_STAGES = 13;
    localparam int JDC_ST_OUT = JDC_STAGES - 1;

    localparam int JDC_REFORM_DAY = 2299160;
    localparam int JDC_GREG_OFS   = 7468865;
    localparam int JDC_CENT_DIV   = 146097;
    localparam int JDC_YEAR_DIV   = 36525;
    localparam int JDC_C_OFS      = 1524;
    localparam int JDC_YEAR_MUL   = 100;
    localparam int JDC_YEAR_OFS   = 12210;
    localparam int JDC_E_MUL      = 1461;
    localparam int JDC_YEAR_LATE  = 4716;
    localparam int JDC_YEAR_EARLY = 4715;

    typedef struct packed {
        logic [JDC_STAGES-1:0] load;
        logic [JDC_STAGES-1:0] valid;
    } jdc_ctl_t;

    // floor(30.6001 * g)
    function automatic logic [8:0] jdc_month_base(input logic [3:0] g);
        logic [8:0] base;
        case (g)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd30;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd91;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd183;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd244;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd336;
            4'd12:   base = 9'd367;
            4'd13:   base = 9'd397;
            4'd14:   base = 9'd428;
            default: base = 9'd459;
        endcase
        return base;
    endfunction

endpackage

### hw/rtl/jdc_cdiv.sv
// Three-stage exact division by a constant: reciprocal estimate, back-multiply, correct.
module jdc_cdiv #(
    parameter int              X_W         = 26,
    parameter int              DIV         = 146097,
    parameter longint unsigned RECIP       = 459,
    parameter int              Q_W         = 9,
    parameter int              FIRST_STAGE = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  jdc_pkg::jdc_ctl_t  ctl,
    input  logic [X_W-1:0]     x,
    output logic [Q_W-1:0]     q
);

    localparam int P_W = X_W + Q_W;

    logic [X_W-1:0] x1_reg;
    logic [Q_W-1:0] est1_reg;
    logic [X_W-1:0] x2_reg;
    logic [Q_W-1:0] est2_reg;
    logic [X_W-1:0] prod2_reg;
    logic [Q_W-1:0] q_reg;

    logic [P_W-1:0] est_full;
    logic [Q_W-1:0] est1_next;
    logic [X_W-1:0] prod2_next;
    logic [X_W-1:0] resid;
    logic [Q_W-1:0] q_next;

    assign est_full   = P_W'(x) * P_W'(RECIP);
    assign est1_next  = est_full[P_W-1:X_W];
    assign prod2_next = X_W'(X_W'(est1_reg) * X_W'(DIV));
    assign resid      = x2_reg - prod2_reg;
    assign q_next     = (resid >= X_W'(DIV)) ? est2_reg + Q_W'(1) : est2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[FIRST_STAGE])
        begin
            x1_reg   <= x;
            est1_reg <= est1_next;
        end
        if (ctl.load[FIRST_STAGE+1])
        begin
            x2_reg    <= x1_reg;
            est2_reg  <= est1_reg;
            prod2_reg <= prod2_next;
        end
        if (ctl.load[FIRST_STAGE+2])
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

    a_resid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid[FIRST_STAGE+1] |-> ((X_W+1)'(resid) < (X_W+1)'(2 * DIV)))
        else $error("reciprocal estimate off by more than one");

endmodule

### hw/rtl/jdc_cal.sv
// Calendar date pipeline: century correction and year split by constant division, month split by table lookup.
module jdc_cal #(
    parameter int DAY_INT_BITS = jdc_pkg::JDC_DAY_INT_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  jdc_pkg::jdc_ctl_t       ctl,
    input  logic [DAY_INT_BITS:0]   day_num,
    output logic signed [15:0]      year,
    output logic [3:0]              month,
    output logic [4:0]              day_of_month
);

    localparam int DN_W = DAY_INT_BITS + 1;
    localparam int XA_W = DN_W + 2;
    localparam int C_W  = DN_W + 1;
    localparam int XD_W = C_W + 7;

    localparam longint unsigned RECIP_A = (64'd1 << XA_W) / jdc_pkg::JDC_CENT_DIV;
    localparam longint unsigned RECIP_D = (64'd1 << XD_W) / jdc_pkg::JDC_YEAR_DIV;
    localparam int QA_W = $clog2(RECIP_A + 1);
    localparam int QD_W = $clog2(RECIP_D + 1);

    localparam int ST_GREG = 1;
    localparam int ST_DIVA = 2;
    localparam int ST_C    = ST_DIVA + 3;
    localparam int ST_X    = ST_C + 1;
    localparam int ST_DIVD = ST_X + 1;
    localparam int ST_REM  = ST_DIVD + 3;
    localparam int ST_G    = ST_REM + 1;
    localparam int ST_OUT  = jdc_pkg::JDC_ST_OUT;

    logic [DN_W-1:0] dn1_reg;
    logic            greg1_reg;
    logic [XA_W-1:0] x1_reg;
    logic [DN_W-1:0] dn_pipe_reg [3];
    logic            greg_pipe_reg [3];
    logic [C_W-1:0]  c5_reg;
    logic [XD_W-1:0] x6_reg;
    logic [8:0]      clow_pipe_reg [4];
    logic [8:0]      rem10_reg;
    logic [15:0]     d10_reg;
    logic [3:0]      g11_reg;
    logic [8:0]      rem11_reg;
    logic [15:0]     d11_reg;
    logic signed [15:0] year_reg;
    logic [3:0]      month_reg;
    logic [4:0]      dom_reg;

    logic [XA_W-1:0] x1_next;
    logic [QA_W-1:0] a_q;
    logic [QD_W-1:0] d_q;
    logic [C_W-1:0]  b_sum;
    logic [C_W-1:0]  c5_next;
    logic [XD_W-1:0] x6_next;
    logic [21:0]     e_prod;
    logic [8:0]      rem10_next;
    logic [14:0]     month_hit;
    logic [3:0]      month_next;
    logic [4:0]      dom_next;
    logic [15:0]     year_next;

    assign x1_next = {day_num, 2'b00} - XA_W'(jdc_pkg::JDC_GREG_OFS);

    jdc_cdiv #(
        .X_W         (XA_W),
        .DIV         (jdc_pkg::JDC_CENT_DIV),
        .RECIP       (RECIP_A),
        .Q_W         (QA_W),
        .FIRST_STAGE (ST_DIVA)
    ) u_div_cent (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (x1_reg),
        .q     (a_q)
    );

    assign b_sum = C_W'(dn_pipe_reg[2]) + C_W'(1) + C_W'(a_q) - C_W'(a_q >> 2);
    assign c5_next = (greg_pipe_reg[2] ? b_sum : C_W'(dn_pipe_reg[2]))
                     + C_W'(jdc_pkg::JDC_C_OFS);
    assign x6_next = XD_W'(c5_reg) * XD_W'(jdc_pkg::JDC_YEAR_MUL)
                     - XD_W'(jdc_pkg::JDC_YEAR_OFS);

    jdc_cdiv #(
        .X_W         (XD_W),
        .DIV         (jdc_pkg::JDC_YEAR_DIV),
        .RECIP       (RECIP_D),
        .Q_W         (QD_W),
        .FIRST_STAGE (ST_DIVD)
    ) u_div_year (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (x6_reg),
        .q     (d_q)
    );

    // only the low nine bits of c - floor(365.25 d) matter, as the difference stays below 512
    assign e_prod     = 22'(d_q) * 22'(jdc_pkg::JDC_E_MUL);
    assign rem10_next = clow_pipe_reg[3] - e_prod[10:2];

    always_comb
    begin
        for (int k = 1; k < 16; k++)
        begin
            month_hit[k-1] = rem10_reg >= (jdc_pkg::jdc_month_base(4'(k)) + 9'd1);
        end
    end

    assign month_next = (g11_reg < 4'd14) ? g11_reg - 4'd1 : g11_reg - 4'd13;
    assign dom_next   = 5'(rem11_reg - jdc_pkg::jdc_month_base(g11_reg));
    assign year_next  = d11_reg - ((month_next > 4'd2) ? 16'(jdc_pkg::JDC_YEAR_LATE)
                                                       : 16'(jdc_pkg::JDC_YEAR_EARLY));

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_GREG])
        begin
            dn1_reg   <= day_num;
            greg1_reg <= day_num > DN_W'(jdc_pkg::JDC_REFORM_DAY);
            x1_reg    <= x1_next;
        end
        if (ctl.load[ST_DIVA])
        begin
            dn_pipe_reg[0]   <= dn1_reg;
            greg_pipe_reg[0] <= greg1_reg;
        end
        for (int i = 1; i < 3; i++)
        begin
            if (ctl.load[ST_DIVA+i])
            begin
                dn_pipe_reg[i]   <= dn_pipe_reg[i-1];
                greg_pipe_reg[i] <= greg_pipe_reg[i-1];
            end
        end
        if (ctl.load[ST_C])
        begin
            c5_reg <= c5_next;
        end
        if (ctl.load[ST_X])
        begin
            x6_reg           <= x6_next;
            clow_pipe_reg[0] <= c5_reg[8:0];
        end
        for (int i = 1; i < 4; i++)
        begin
            if (ctl.load[ST_X+i])
            begin
                clow_pipe_reg[i] <= clow_pipe_reg[i-1];
            end
        end
        if (ctl.load[ST_REM])
        begin
            rem10_reg <= rem10_next;
            d10_reg   <= 16'(d_q);
        end
        if (ctl.load[ST_G])
        begin
            g11_reg   <= 4'($countones(month_hit));
            rem11_reg <= rem10_reg;
            d11_reg   <= d10_reg;
        end
        if (ctl.load[ST_OUT])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            dom_reg   <= dom_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid[ST_OUT] |-> (month_reg != 4'd0 && month_reg <= 4'd12 && dom_reg != 5'd0))
        else $error("calendar date out of range");

endmodule

### hw/rtl/jdc_tod.sv
// Time of day pipeline: hours, minutes and seconds cut from the day fraction.
module jdc_tod (
    input  logic               clk,
    input  logic               rst_n,
    input  jdc_pkg::jdc_ctl_t  ctl,
    input  logic [31:0]        frac,
    output logic [4:0]         hours,
    output logic [5:0]         minutes,
    output logic [21:0]        seconds_fx
);

    localparam int ST_H = 1;
    localparam int ST_M = 2;
    localparam int ST_S = 3;
    localparam int DLY  = jdc_pkg::JDC_ST_OUT - ST_S;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [21:0] seconds;
    } tod_t;

    logic [4:0]  hours1_reg;
    logic [31:0] f1_reg;
    logic [4:0]  hours2_reg;
    logic [5:0]  minutes2_reg;
    logic [31:0] f2_reg;
    tod_t        tod3_reg;
    tod_t        tod_pipe_reg [DLY];

    logic [36:0] t1;
    logic [37:0] t2;
    logic [37:0] t3;

    assign t1 = 37'(frac) * 37'(24);
    assign t2 = 38'(f1_reg) * 38'(60);
    assign t3 = 38'(f2_reg) * 38'(60);

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_H])
        begin
            hours1_reg <= t1[36:32];
            f1_reg     <= t1[31:0];
        end
        if (ctl.load[ST_M])
        begin
            hours2_reg   <= hours1_reg;
            minutes2_reg <= t2[37:32];
            f2_reg       <= t2[31:0];
        end
        if (ctl.load[ST_S])
        begin
            tod3_reg.hours   <= hours2_reg;
            tod3_reg.minutes <= minutes2_reg;
            tod3_reg.seconds <= t3[37:16];
        end
        if (ctl.load[ST_S+1])
        begin
            tod_pipe_reg[0] <= tod3_reg;
        end
        for (int i = 1; i < DLY; i++)
        begin
            if (ctl.load[ST_S+1+i])
            begin
                tod_pipe_reg[i] <= tod_pipe_reg[i-1];
            end
        end
    end

    assign hours      = tod_pipe_reg[DLY-1].hours;
    assign minutes    = tod_pipe_reg[DLY-1].minutes;
    assign seconds_fx = tod_pipe_reg[DLY-1].seconds;

    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid[jdc_pkg::JDC_ST_OUT] |->
            (tod_pipe_reg[DLY-1].hours <= 5'd23 && tod_pipe_reg[DLY-1].minutes <= 6'd59))
        else $error("time of day out of range");

endmodule

### hw/rtl/julian_date_to_calendar.sv
// Top level of the Julian date to calendar date and time of day converter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall   | julian_date_fx
//  out     | source    | out_valid / out_stall | year, month, day_of_month, hours, minutes,
//          |           |                       | seconds_fx
//
//  One item per cycle sustained while out_stall is low; items leave in the order of acceptance.
//  The pipeline depth is set by the two three-stage reciprocal dividers in the calendar path.
//  Reset clears the stage valid bits only; the pipeline is empty after reset.
//  A stage holds only while it and every stage after it hold an item and out_stall is high,
//  so bubbles close up and items keep entering while a result waits.
module julian_date_to_calendar #(
    parameter int DAY_INT_BITS = jdc_pkg::JDC_DAY_INT_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [jdc_pkg::JDC_IN_W-1:0] julian_date_fx,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          year,
    output logic [3:0]                  month,
    output logic [4:0]                  day_of_month,
    output logic [4:0]                  hours,
    output logic [5:0]                  minutes,
    output logic [21:0]                 seconds_fx
);

    localparam int FB      = jdc_pkg::JDC_FRAC_BITS;
    localparam int IN_BITS = DAY_INT_BITS + FB;
    localparam int N       = jdc_pkg::JDC_STAGES;

    logic [N-1:0]            valid_reg;
    logic [DAY_INT_BITS:0]   dn0_reg;
    logic [FB-1:0]           frac0_reg;

    logic [N-1:0]            ready;
    logic [IN_BITS-1:0]      jd_in;
    logic [IN_BITS:0]        jd;
    jdc_pkg::jdc_ctl_t       ctl;

    for (genvar k = 0; k < N; k++)
    begin : g_ready
        assign ready[k] = !out_stall || !(&valid_reg[N-1:k]);
    end

    assign ctl.load  = ready;
    assign ctl.valid = valid_reg;

    // add half a day so the civil day starts at midnight
    assign jd_in = IN_BITS'(julian_date_fx);
    assign jd    = (IN_BITS+1)'(jd_in) + ((IN_BITS+1)'(1) << (FB - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            dn0_reg   <= jd[IN_BITS:FB];
            frac0_reg <= jd[FB-1:0];
        end
    end

    jdc_cal #(
        .DAY_INT_BITS (DAY_INT_BITS)
    ) u_cal (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .day_num      (dn0_reg),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    jdc_tod u_tod (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .frac       (frac0_reg),
        .hours      (hours),
        .minutes    (minutes),
        .seconds_fx (seconds_fx)
    );

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[N-1];

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[N-1] |-> !in_stall)
        else $error("input held while the output stage is empty");

endmodule

### tb/testbench.sv
// Self-checking testbench for the Julian date to calendar date and time converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 10000;
    localparam int REPORT_MAX  = 10;
    localparam longint unsigned HALF_DAY = 64'd1 << (jdc_pkg::JDC_FRAC_BITS - 1);
    localparam longint unsigned DATE_MASK =
        (64'd1 << (jdc_pkg::JDC_DAY_INT_BITS + jdc_pkg::JDC_FRAC_BITS)) - 64'd1;
    localparam longint unsigned DAY_TOP = 64'd1 << jdc_pkg::JDC_DAY_INT_BITS;
    localparam longint unsigned FRAC_MASK = (64'd1 << jdc_pkg::JDC_FRAC_BITS) - 64'd1;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [21:0]        seconds_fx;
    } calendar_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [jdc_pkg::JDC_IN_W-1:0]  julian_date_fx;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [15:0]            year;
    logic [3:0]                    month;
    logic [4:0]                    day_of_month;
    logic [4:0]                    hours;
    logic [5:0]                    minutes;
    logic [21:0]                   seconds_fx;

    calendar_t calendar_due[$];
    int sender_idle_pct;
    int receiver_stall_pct;
    int dates_sent;
    int julian_dates;
    int gregorian_dates;
    int dates_checked;
    int date_mismatches;
    int idle_cycles;

    julian_date_to_calendar dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .julian_date_fx (julian_date_fx),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .year           (year),
        .month          (month),
        .day_of_month   (day_of_month),
        .hours          (hours),
        .minutes        (minutes),
        .seconds_fx     (seconds_fx)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic calendar_t predict_calendar(
        input logic [jdc_pkg::JDC_IN_W-1:0] jdate);
        longint unsigned jd, day_num, frac, a, b, c, d, e, g, rem, dom, mon, t;
        longint yr;
        calendar_t r;
        jd      = (longint'(jdate) & DATE_MASK) + HALF_DAY;
        day_num = jd >> jdc_pkg::JDC_FRAC_BITS;
        frac    = jd & FRAC_MASK;
        if (day_num > jdc_pkg::JDC_REFORM_DAY)
        begin
            a = (64'd4 * day_num - jdc_pkg::JDC_GREG_OFS) / jdc_pkg::JDC_CENT_DIV;
            b = day_num + 64'd1 + a - (a / 64'd4);
        end
        else
        begin
            b = day_num;
        end
        c   = b + jdc_pkg::JDC_C_OFS;
        d   = (jdc_pkg::JDC_YEAR_MUL * c - jdc_pkg::JDC_YEAR_OFS) / jdc_pkg::JDC_YEAR_DIV;
        e   = (jdc_pkg::JDC_E_MUL * d) / 64'd4;
        rem = c - e;
        g   = (64'd10000 * rem) / 64'd306001;
        dom = rem - (64'd306001 * g) / 64'd10000;
        mon = (g < 64'd14) ? (g - 64'd1) : (g - 64'd13);
        yr  = (mon > 64'd2) ? (longint'(d) - jdc_pkg::JDC_YEAR_LATE)
                            : (longint'(d) - jdc_pkg::JDC_YEAR_EARLY);
        r.year         = 16'(yr);
        r.month        = 4'(mon);
        r.day_of_month = 5'(dom);
        t = frac * 64'd24;
        r.hours = 5'(t >> jdc_pkg::JDC_FRAC_BITS);
        t = (t & FRAC_MASK) * 64'd60;
        r.minutes = 6'(t >> jdc_pkg::JDC_FRAC_BITS);
        t = (t & FRAC_MASK) * 64'd60;
        r.seconds_fx = 22'(t >> (jdc_pkg::JDC_FRAC_BITS - 16));
        return r;
    endfunction

    function automatic logic [jdc_pkg::JDC_IN_W-1:0] date_of(input longint unsigned day,
                                                             input longint unsigned frac);
        return jdc_pkg::JDC_IN_W'((day << jdc_pkg::JDC_FRAC_BITS) | (frac & 64'hFFFF_FFFF));
    endfunction

    function automatic longint unsigned pick_fraction();
        case ($urandom_range(5))
            0:       return 64'h0000_0000;
            1:       return 64'h7FFF_FFFF;
            2:       return 64'h8000_0000;
            3:       return 64'hFFFF_FFFF;
            default: return longint'($urandom);
        endcase
    endfunction

    task automatic send_date(input logic [jdc_pkg::JDC_IN_W-1:0] jdate);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        julian_date_fx <= jdate;
        do
            @(posedge clk);
        while (in_stall);
        calendar_due.push_back(predict_calendar(jdate));
        dates_sent++;
        if ((((longint'(jdate) & DATE_MASK) + HALF_DAY) >> jdc_pkg::JDC_FRAC_BITS)
            > jdc_pkg::JDC_REFORM_DAY)
            gregorian_dates++;
        else
            julian_dates++;
    endtask

    task automatic test_field_extremes();
        send_date('0);
        send_date('1);
        send_date(date_of(DAY_TOP - 1, 64'h8000_0000));
        send_date(date_of(DAY_TOP - 1, 64'h7FFF_FFFF));
        send_date(date_of(0, 64'hFFFF_FFFF));
        send_date(date_of(0, 64'h7FFF_FFFF));
        send_date(date_of(1, 64'h0000_0001));
        send_date(date_of(1721057, 64'h8000_0000));
        send_date(date_of(1721117, 64'h8000_0000));
    endtask

    task automatic test_reform_boundary();
        send_date(date_of(jdc_pkg::JDC_REFORM_DAY - 1, 64'h8000_0000));
        send_date(date_of(jdc_pkg::JDC_REFORM_DAY - 1, 64'h7FFF_FFFF));
        send_date(date_of(jdc_pkg::JDC_REFORM_DAY, 64'h7FFF_FFFF));
        send_date(date_of(jdc_pkg::JDC_REFORM_DAY, 64'h8000_0000));
        send_date(date_of(jdc_pkg::JDC_REFORM_DAY + 1, 64'h0000_0000));
    endtask

    task automatic test_leap_days();
        send_date(date_of(2451545, 64'h0000_0000));
        send_date(date_of(2451604, 64'h8000_0000));
        send_date(date_of(2415078, 64'h8000_0000));
        send_date(date_of(2415079, 64'h8000_0000));
        send_date(date_of(2451909, 64'hFFFF_FFFF));
        send_date(date_of(2305507, 64'h8000_0000));
    endtask

    task automatic test_random_dates(input int count);
        longint unsigned day;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(4))
                0: send_date(jdc_pkg::JDC_IN_W'({$urandom, $urandom}));
                1:
                begin
                    day = jdc_pkg::JDC_REFORM_DAY + $urandom_range(8) - 4;
                    send_date(date_of(day, pick_fraction()));
                end
                2:
                begin
                    day = $urandom_range(2600000, 2000000);
                    send_date(date_of(day, pick_fraction()));
                end
                3:
                begin
                    day = $urandom_range(800000);
                    send_date(date_of(day, pick_fraction()));
                end
                default:
                begin
                    day = DAY_TOP - 1 - $urandom_range(40000);
                    send_date(date_of(day, pick_fraction()));
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        calendar_t got;
        calendar_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{year, month, day_of_month, hours, minutes, seconds_fx};
            if (calendar_due.size() == 0)
            begin
                date_mismatches++;
                if (date_mismatches <= REPORT_MAX)
                    $display("unexpected result: %0d-%0d-%0d %0d:%0d s=%0h",
                             got.year, got.month, got.day_of_month,
                             got.hours, got.minutes, got.seconds_fx);
            end
            else
            begin
                want = calendar_due.pop_front();
                dates_checked++;
                if (got.year !== want.year || got.month !== want.month ||
                    got.day_of_month !== want.day_of_month || got.hours !== want.hours ||
                    got.minutes !== want.minutes || got.seconds_fx !== want.seconds_fx)
                begin
                    date_mismatches++;
                    if (date_mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected %0d-%0d-%0d %0d:%0d s=%0h",
                                 want.year, want.month, want.day_of_month,
                                 want.hours, want.minutes, want.seconds_fx);
                        $display("          got      %0d-%0d-%0d %0d:%0d s=%0h",
                                 got.year, got.month, got.day_of_month,
                                 got.hours, got.minutes, got.seconds_fx);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid          <= 1'b0;
        julian_date_fx    <= '0;
        out_stall         <= 1'b0;
        sender_idle_pct    = 28;
        receiver_stall_pct = 77;
        dates_sent         = 0;
        julian_dates       = 0;
        gregorian_dates    = 0;
        dates_checked      = 0;
        date_mismatches    = 0;
        idle_cycles        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_reform_boundary();
        test_leap_days();
        test_random_dates(330);
        sender_idle_pct    = 77;
        receiver_stall_pct = 28;
        test_random_dates(330);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_dates(330);

        in_valid <= 1'b0;
        while (calendar_due.size() != 0)
            @(posedge clk);
        repeat (jdc_pkg::JDC_STAGES + 8) @(posedge clk);

        $display("converted %0d dates (%0d Julian calendar, %0d Gregorian), %0d checked",
                 dates_sent, julian_dates, gregorian_dates, dates_checked);
        $display("handshake pressure: sender-heavy, receiver-heavy and back-to-back phases");
        if (date_mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
